>>> design/tbbeq_pkg.sv
// Shared types and constants for the three-band biquad equalizer.
// Holds opcodes, coefficient codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package tbbeq_pkg;

  // Default configuration of the filter bank.
  localparam int NumBandsDef    = 3;
  localparam int CoefWidthDef   = 24;
  localparam int SignalWidthDef = 32;

  localparam int CoefsPerBand = 5;
  localparam int SampleW      = 16;
  // Band index carried in the command bus; wide enough for the largest bank.
  localparam int BandIdxW     = 3;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COEF_WR = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_e;

  // Coefficient codes, also used as the tap order of one section.
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                start;     // latch the sample and form the section input
    logic                coef_we;   // coefficient write transaction
    logic                hist_clr;  // zero both histories
    logic                issue;     // fetch one tap into the multiplier
    logic                acc_clr;   // start a new section sum
    logic [2:0]          tap;
    logic [BandIdxW-1:0] band;
    logic                wb;        // write back the section output
    logic                out_load;  // load the output register
    logic                out_byp;   // output the raw sample
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> design/three_band_biquad_equalizer_core.sv
// Top level of the three-band biquad equalizer.
// Instantiates tbbeq_ctrl and tbbeq_dp; types and defaults come from tbbeq_pkg.
//
// Usage: transactions enter on in_valid_i/in_stall_o. Opcode 0 filters one 16-bit
// sample through the cascaded sections, opcode 1 writes one Q4.20 coefficient,
// opcode 2 zeroes the section histories; only opcode 0 yields a transaction on
// out_valid_o/out_stall_i. eq_enable is written through cfg_we_i/cfg_wdata_i.
// A filtered sample passes through each section in turn: its five taps run
// through one shared multiplier, the operand and product registers drain into
// the accumulator, and the section output is written back. A bypassed sample
// is loaded raw into the output; coefficient writes and clears keep the block idle.
// The block takes one transaction at a time; in_stall_o is high while it works.
// One finished sample can wait in the output register while the next one is
// computed; if that sample is still stalled when the next finishes, the block
// holds and keeps in_stall_o high. Reset loads pass-through coefficients,
// zeroes the histories, sets eq_enable and empties the output register.
`default_nettype none

module three_band_biquad_equalizer_core
  import tbbeq_pkg::*;
#(
  parameter int NUM_BANDS    = NumBandsDef,
  parameter int COEF_WIDTH   = CoefWidthDef,
  parameter int SIGNAL_WIDTH = SignalWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic        [1:0]            opcode_i,
  input  wire logic signed [SampleW-1:0]    sample_in_i,
  input  wire logic        [1:0]            band_select_i,
  input  wire logic        [2:0]            coef_select_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed      [SampleW-1:0]    sample_out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_wdata_i
);

  cmd_t  cmd_w;
  stat_t stat_w;

  tbbeq_ctrl #(
    .NUM_BANDS(NUM_BANDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_o      (cmd_w),
    .stat_i     (stat_w)
  );

  tbbeq_dp #(
    .NUM_BANDS   (NUM_BANDS),
    .COEF_WIDTH  (COEF_WIDTH),
    .SIGNAL_WIDTH(SIGNAL_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_w),
    .stat_o       (stat_w),
    .sample_in_i  (sample_in_i),
    .band_select_i(band_select_i),
    .coef_select_i(coef_select_i),
    .coef_value_i (coef_value_i),
    .sample_out_o (sample_out_o)
  );

  // A pending result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_w.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while a result is pending");

  // Write-back only reads a completed sum.
  a_wb_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_w.wb |-> !stat_w.pipe_busy)
    else $error("section write-back while the multiplier pipeline is busy");

  // Tap fetches only happen while the input side is held off.
  a_issue_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_w.issue |-> in_stall_o)
    else $error("tap issued while input transactions are accepted");

  // Loading the output register always ends the sample and frees the input.
  a_load_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_w.out_load |=> (!in_stall_o && out_valid_o))
    else $error("output load did not return the block to idle");

endmodule

`default_nettype wire

>>> design/tbbeq_dp.sv
// Datapath of the equalizer: coefficient table, section histories and the
// shared multiply-accumulate pipeline with output scaling. Uses tbbeq_pkg.
`default_nettype none

module tbbeq_dp
  import tbbeq_pkg::*;
#(
  parameter int NUM_BANDS    = NumBandsDef,
  parameter int COEF_WIDTH   = CoefWidthDef,
  parameter int SIGNAL_WIDTH = SignalWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cmd_t                         cmd_i,
  output stat_t                             stat_o,
  input  wire logic signed [SampleW-1:0]    sample_in_i,
  input  wire logic        [1:0]            band_select_i,
  input  wire logic        [2:0]            coef_select_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_value_i,
  output logic signed      [SampleW-1:0]    sample_out_o
);

  localparam int CoefFrac  = COEF_WIDTH - 4;
  localparam int SigFrac   = SIGNAL_WIDTH - 8;
  localparam int OutShift  = SigFrac - 15;
  localparam int ProdW     = COEF_WIDTH + SIGNAL_WIDTH;
  localparam int AccW      = ProdW + 3;
  localparam int NumCoefs  = NUM_BANDS * CoefsPerBand;
  localparam int CidxW     = $clog2(NumCoefs);
  localparam int BandW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam logic signed [COEF_WIDTH-1:0] CoefOne = COEF_WIDTH'(1) << CoefFrac;
  localparam logic signed [SIGNAL_WIDTH-1:0] SigMax = {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
  localparam logic signed [SIGNAL_WIDTH-1:0] SigMin = {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};
  localparam logic signed [SIGNAL_WIDTH:0] RndMask =
    (SIGNAL_WIDTH+1)'((64'(1) << OutShift) - 64'(1));
  localparam logic signed [SampleW-1:0] OutMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] OutMin = {1'b1, {(SampleW-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]   coef_q [NumCoefs];
  logic signed [SIGNAL_WIDTH-1:0] xh_q   [NUM_BANDS][2];
  logic signed [SIGNAL_WIDTH-1:0] yh_q   [NUM_BANDS][2];

  logic signed [SIGNAL_WIDTH-1:0] x_q;
  logic signed [SampleW-1:0]      sample_q;
  logic signed [COEF_WIDTH-1:0]   op_c_q;
  logic signed [SIGNAL_WIDTH-1:0] op_s_q;
  logic                           op_sub_q;
  logic                           op_v_q;
  logic signed [ProdW-1:0]        prod_q;
  logic                           prod_sub_q;
  logic                           prod_v_q;
  logic signed [AccW-1:0]         acc_q;
  logic signed [SampleW-1:0]      sample_out_q;

  logic [BandW-1:0]               band;
  logic [CidxW-1:0]               rd_idx;
  logic [CidxW-1:0]               wr_idx;
  logic                           wr_ok;
  logic signed [SIGNAL_WIDTH-1:0] operand;
  logic                           operand_sub;
  logic signed [AccW-1:0]         acc_sh;
  logic [AccW-SIGNAL_WIDTH:0]     acc_top;
  logic signed [SIGNAL_WIDTH-1:0] y_w;
  logic signed [SIGNAL_WIDTH:0]   rnd_w;
  logic signed [SIGNAL_WIDTH:0]   q_full;
  logic [SIGNAL_WIDTH-SampleW+1:0] q_top;
  logic signed [SampleW-1:0]      q_w;

  assign band   = cmd_i.band[BandW-1:0];
  assign rd_idx = CidxW'(32'(band) * CoefsPerBand + 32'(cmd_i.tap));
  assign wr_ok  = (32'(band_select_i) < NUM_BANDS) && (coef_select_i <= COEF_A2);
  assign wr_idx = CidxW'(32'(band_select_i) * CoefsPerBand + 32'(coef_select_i));

  always_comb begin
    operand     = x_q;
    operand_sub = 1'b0;
    case (cmd_i.tap)
      COEF_B0: operand = x_q;
      COEF_B1: operand = xh_q[band][0];
      COEF_B2: operand = xh_q[band][1];
      COEF_A1: begin
        operand     = yh_q[band][0];
        operand_sub = 1'b1;
      end
      COEF_A2: begin
        operand     = yh_q[band][1];
        operand_sub = 1'b1;
      end
      default: operand = x_q;
    endcase
  end

  // Section output: floor shift of the sum, saturated to the signal range.
  always_comb begin
    acc_sh  = acc_q >>> CoefFrac;
    acc_top = acc_sh[AccW-1:SIGNAL_WIDTH-1];
    if ((&acc_top) || !(|acc_top)) begin
      y_w = acc_sh[SIGNAL_WIDTH-1:0];
    end else begin
      y_w = acc_sh[AccW-1] ? SigMin : SigMax;
    end
  end

  // Final scaling truncates toward zero, then saturates to 16 bits.
  always_comb begin
    rnd_w  = (SIGNAL_WIDTH+1)'(x_q) + (x_q[SIGNAL_WIDTH-1] ? RndMask : '0);
    q_full = rnd_w >>> OutShift;
    q_top  = q_full[SIGNAL_WIDTH:SampleW-1];
    if ((&q_top) || !(|q_top)) begin
      q_w = q_full[SampleW-1:0];
    end else begin
      q_w = q_full[SIGNAL_WIDTH] ? OutMin : OutMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= ((i % CoefsPerBand) == 0) ? CoefOne : '0;
      end
    end else if (cmd_i.coef_we && wr_ok) begin
      coef_q[wr_idx] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        xh_q[b][0] <= '0;
        xh_q[b][1] <= '0;
        yh_q[b][0] <= '0;
        yh_q[b][1] <= '0;
      end
    end else if (cmd_i.hist_clr) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        xh_q[b][0] <= '0;
        xh_q[b][1] <= '0;
        yh_q[b][0] <= '0;
        yh_q[b][1] <= '0;
      end
    end else if (cmd_i.wb) begin
      xh_q[band][1] <= xh_q[band][0];
      xh_q[band][0] <= x_q;
      yh_q[band][1] <= yh_q[band][0];
      yh_q[band][0] <= y_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      op_v_q   <= cmd_i.issue;
      prod_v_q <= op_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q      <= SIGNAL_WIDTH'(sample_in_i) <<< OutShift;
      sample_q <= sample_in_i;
    end else if (cmd_i.wb) begin
      x_q <= y_w;
    end
    if (cmd_i.issue) begin
      op_c_q   <= coef_q[rd_idx];
      op_s_q   <= operand;
      op_sub_q <= operand_sub;
    end
    prod_q     <= ProdW'(op_c_q * op_s_q);
    prod_sub_q <= op_sub_q;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= prod_sub_q ? acc_q - AccW'(prod_q) : acc_q + AccW'(prod_q);
    end
    if (cmd_i.out_load) begin
      sample_out_q <= cmd_i.out_byp ? sample_q : q_w;
    end
  end

  assign stat_o.pipe_busy = op_v_q | prod_v_q;
  assign sample_out_o     = sample_out_q;

endmodule

`default_nettype wire

>>> design/tbbeq_ctrl.sv
// Controller of the equalizer: decodes transactions, sequences the taps of each
// section through the datapath and owns the handshakes. Uses tbbeq_pkg.
`default_nettype none

module tbbeq_ctrl
  import tbbeq_pkg::*;
#(
  parameter int NUM_BANDS = NumBandsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  output cmd_t            cmd_o,
  input  wire stat_t      stat_i
);

  localparam int BandW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BandW-1:0] LastBand = BandW'(NUM_BANDS - 1);

  state_e           state_q, state_d;
  logic [2:0]       tap_q, tap_d;
  logic [BandW-1:0] band_q, band_d;
  logic             byp_q, byp_d;
  logic             en_q;
  logic             out_valid_q;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_e'(opcode_i) == OP_SAMPLE)) begin
          state_d = en_q ? ST_MAC : ST_FINISH;
        end
      end
      ST_MAC: begin
        if (tap_q == COEF_A2) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = (band_q == LastBand) ? ST_FINISH : ST_MAC;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.tap  = tap_q;
    cmd_o.band = BandIdxW'(band_q);
    tap_d      = tap_q;
    band_d     = band_q;
    byp_d      = byp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_e'(opcode_i))
            OP_SAMPLE: begin
              cmd_o.start = 1'b1;
              byp_d       = !en_q;
              tap_d       = COEF_B0;
              band_d      = '0;
            end
            OP_COEF_WR: cmd_o.coef_we  = 1'b1;
            OP_CLEAR:   cmd_o.hist_clr = 1'b1;
            default:    cmd_o.start    = 1'b0;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.issue   = 1'b1;
        cmd_o.acc_clr = (tap_q == COEF_B0);
        tap_d         = tap_q + 3'd1;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.wb = 1'b1;
          tap_d    = COEF_B0;
          band_d   = band_q + BandW'(1);
        end
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
        cmd_o.out_byp  = byp_q;
      end
      default: cmd_o.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= COEF_B0;
      band_q      <= '0;
      byp_q       <= 1'b0;
      en_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      band_q  <= band_d;
      byp_q   <= byp_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
